/* design/sud_pkg.sv */
`timescale 1ns / 1ps
// Package for the signed/unsigned divider: field widths, mode codes, sign flags.
// No dependencies.

package sud_pkg;

  localparam int unsigned FIELD_W   = 32;  // width of every payload field on the ports
  localparam int unsigned WIDTH_DEF = 32;  // default operand width

  localparam logic KIND_UNSIGNED = 1'b0;
  localparam logic KIND_SIGNED   = 1'b1;

  // Sign fix-up carried down the pipe alongside the magnitudes
  typedef struct packed {
    logic rem_neg;  // negate remainder (dividend was negative)
    logic quo_neg;  // negate quotient (operand signs differ)
  } sud_sign_t;

endpackage

/* design/sud_if.sv */
`timescale 1ns / 1ps
// Request and result channels of the divider, valid/ready handshake.
// Depends on sud_pkg.

interface sud_in_if;
  import sud_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [FIELD_W-1:0] dividend;
  logic [FIELD_W-1:0] divisor;

  modport source (output valid, kind, dividend, divisor, input ready);
  modport sink   (input valid, kind, dividend, divisor, output ready);
endinterface

interface sud_out_if;
  import sud_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] quotient;
  logic [FIELD_W-1:0] remainder;

  modport source (output valid, quotient, remainder, input ready);
  modport sink   (input valid, quotient, remainder, output ready);
endinterface

/* design/signed_unsigned_divider.sv */
`timescale 1ns / 1ps
// Pipelined signed/unsigned restoring divider, top level.
// Depends on sud_pkg, sud_if, sud_prep, sud_cell, sud_post.
//
//   channel | dir | payload                      | request taken when
//   in_i    | in  | kind, dividend, divisor      | in_i.valid & in_i.ready
//   out_o   | out | quotient, remainder          | out_o.valid & out_o.ready
//
// The pipe is one magnitude stage, WIDTH step cells, and one sign-fix
// and output stage. A new request is taken every cycle unless a stalled output has filled the pipe.
// Each stage has its own valid bit; ready ripples back so bubbles are squeezed out
// and requests keep entering while a result waits at the output.
// Reset clears the valid bits only; the pipe is empty afterward.

module signed_unsigned_divider #(
  parameter int unsigned WIDTH = sud_pkg::WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sud_in_if.sink    in_i,
  sud_out_if.source out_o
);
  import sud_pkg::*;

  logic               valid_s [0:WIDTH];
  logic               ready_s [0:WIDTH];
  logic [WIDTH-1:0]   rem_s   [0:WIDTH];
  logic [WIDTH-1:0]   aq_s    [0:WIDTH];
  logic [WIDTH-1:0]   d_s     [0:WIDTH];
  sud_sign_t          sign_s  [0:WIDTH];
  logic               post_ready;

  sud_prep #(.W(WIDTH)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .kind_i  (in_i.kind),
    .a_i     (WIDTH'(in_i.dividend)),
    .b_i     (WIDTH'(in_i.divisor)),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .rem_o   (rem_s[0]),
    .aq_o    (aq_s[0]),
    .d_o     (d_s[0]),
    .sign_o  (sign_s[0])
  );

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    sud_cell #(.W(WIDTH)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .rem_i   (rem_s[k]),
      .aq_i    (aq_s[k]),
      .d_i     (d_s[k]),
      .sign_i  (sign_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .aq_o    (aq_s[k+1]),
      .d_o     (d_s[k+1]),
      .sign_o  (sign_s[k+1])
    );
  end

  assign ready_s[WIDTH] = post_ready;

  sud_post #(.W(WIDTH)) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_s[WIDTH]),
    .ready_o     (post_ready),
    .rem_i       (rem_s[WIDTH]),
    .quo_i       (aq_s[WIDTH]),
    .sign_i      (sign_s[WIDTH]),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .quotient_o  (out_o.quotient),
    .remainder_o (out_o.remainder)
  );

  // A taken request always lands in the first stage
  a_prep_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> valid_s[0])
    else $error("request taken but magnitude stage empty");

  // Unsigned requests carry no sign fix-up
  a_unsigned_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.kind == KIND_UNSIGNED) |=> sign_s[0] == '0)
    else $error("unsigned request picked up sign flags");

  // After the last step the remainder magnitude is below a nonzero divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_s[WIDTH] && (d_s[WIDTH] != '0) |-> rem_s[WIDTH] < d_s[WIDTH])
    else $error("final remainder not below divisor");

endmodule

/* design/sud_prep.sv */
`timescale 1ns / 1ps
// First stage: takes operand magnitudes and records the sign fix-up.
// Depends on sud_pkg.

module sud_prep #(
  parameter int unsigned W = sud_pkg::WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               kind_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [W-1:0]       rem_o,
  output logic [W-1:0]       aq_o,
  output logic [W-1:0]       d_o,
  output sud_pkg::sud_sign_t sign_o
);
  import sud_pkg::*;

  logic      sa, sb;
  logic      valid_q;
  logic [W-1:0] ma, mb;
  logic [W-1:0] aq_q, d_q;
  sud_sign_t sign_q;

  assign sa = (kind_i == KIND_SIGNED) & a_i[W-1];
  assign sb = (kind_i == KIND_SIGNED) & b_i[W-1];
  assign ma = sa ? (~a_i + W'(1)) : a_i;
  assign mb = sb ? (~b_i + W'(1)) : b_i;

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      aq_q           <= ma;
      d_q            <= mb;
      sign_q.rem_neg <= sa;
      sign_q.quo_neg <= sa ^ sb;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = '0;  // partial remainder starts empty
  assign aq_o    = aq_q;
  assign d_o     = d_q;
  assign sign_o  = sign_q;
endmodule

/* design/sud_cell.sv */
`timescale 1ns / 1ps
// One restoring division step with its pipeline register.
// Depends on sud_pkg.

module sud_cell #(
  parameter int unsigned W = sud_pkg::WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [W-1:0]       rem_i,
  input  logic [W-1:0]       aq_i,
  input  logic [W-1:0]       d_i,
  input  sud_pkg::sud_sign_t sign_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [W-1:0]       rem_o,
  output logic [W-1:0]       aq_o,
  output logic [W-1:0]       d_o,
  output sud_pkg::sud_sign_t sign_o
);
  import sud_pkg::*;

  logic [W:0]   trial;
  logic [W+1:0] diff;
  logic         borrow;
  logic         q_bit;
  logic [W-1:0] rem_d, aq_d;
  logic         valid_q;
  logic [W-1:0] rem_q, aq_q, d_q;
  sud_sign_t    sign_q;

  // Shift next dividend bit into the remainder, subtract if it fits.
  // aq holds the unconsumed dividend bits on top, quotient bits below.
  assign trial  = {rem_i, aq_i[W-1]};
  assign diff   = {1'b0, trial} - {2'b00, d_i};
  assign borrow = diff[W+1];
  assign q_bit  = ~borrow;
  assign rem_d  = borrow ? trial[W-1:0] : diff[W-1:0];
  assign aq_d   = (aq_i << 1) | W'(q_bit);

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rem_q  <= rem_d;
      aq_q   <= aq_d;
      d_q    <= d_i;
      sign_q <= sign_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign aq_o    = aq_q;
  assign d_o     = d_q;
  assign sign_o  = sign_q;
endmodule

/* design/sud_post.sv */
`timescale 1ns / 1ps
// Last stage: applies the sign fix-up and holds the result for the output channel.
// Depends on sud_pkg.

module sud_post #(
  parameter int unsigned W = sud_pkg::WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [W-1:0]                rem_i,
  input  logic [W-1:0]                quo_i,
  input  sud_pkg::sud_sign_t          sign_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [sud_pkg::FIELD_W-1:0] quotient_o,
  output logic [sud_pkg::FIELD_W-1:0] remainder_o
);
  import sud_pkg::*;

  logic [W-1:0]       q_fix, r_fix;
  logic               valid_q;
  logic [FIELD_W-1:0] quo_q, rem_q;

  assign q_fix = sign_i.quo_neg ? (~quo_i + W'(1)) : quo_i;
  assign r_fix = sign_i.rem_neg ? (~rem_i + W'(1)) : rem_i;

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      quo_q <= FIELD_W'(q_fix);
      rem_q <= FIELD_W'(r_fix);
    end
  end

  assign valid_o     = valid_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
endmodule

/* test/signed_unsigned_divider_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for signed_unsigned_divider: directed corners, then shaped random requests.
// Depends on sud_pkg, sud_if and the divider RTL; predicts each result and compares in order.

module signed_unsigned_divider_test;
  import sud_pkg::*;

  typedef logic [FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t quotient;
    field_t remainder;
  } div_result_t;

  // Predicts quotient/remainder for each accepted request and checks results in order.
  class divide_scoreboard;
    localparam int unsigned W = WIDTH_DEF;
    localparam logic [63:0] MASK = (64'd2 << (W - 1)) - 64'd1;

    div_result_t pending[$];
    int unsigned errors;

    function logic [63:0] negate(logic [63:0] x);
      return (~x + 64'd1) & MASK;
    endfunction

    function void note_request(logic kind, field_t dividend, field_t divisor);
      logic [63:0] a, b, mag_a, mag_b, quo, rem;
      logic sign_a, sign_b;
      div_result_t want;
      a = 64'(dividend) & MASK;
      b = 64'(divisor) & MASK;
      sign_a = (kind == KIND_SIGNED) ? a[W-1] : 1'b0;
      sign_b = (kind == KIND_SIGNED) ? b[W-1] : 1'b0;
      mag_a = sign_a ? negate(a) : a;
      mag_b = sign_b ? negate(b) : b;
      // restoring array with a zero divisor keeps every quotient bit set
      if (mag_b == 64'd0) begin
        quo = MASK;
        rem = mag_a;
      end else begin
        quo = mag_a / mag_b;
        rem = mag_a % mag_b;
      end
      if (sign_a ^ sign_b) quo = negate(quo);
      if (sign_a) rem = negate(rem);
      want.quotient  = field_t'(quo & MASK);
      want.remainder = field_t'(rem & MASK);
      pending.insert(pending.size(), want);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(field_t quotient, field_t remainder);
      div_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result q=%h r=%h", quotient, remainder));
      end else begin
        want = pending.pop_front();
        if (quotient !== want.quotient)
          report_mismatch($sformatf("quotient %h, want %h", quotient, want.quotient));
        if (remainder !== want.remainder)
          report_mismatch($sformatf("remainder %h, want %h", remainder, want.remainder));
      end
    endtask
  endclass

  localparam int unsigned RANDOM_REQUESTS = 1900;
  localparam int unsigned DRAIN_CYCLES    = WIDTH_DEF + 8;

  logic clk_i;
  logic rst_ni;
  bit   burst;  // both sides skip idling while set

  sud_in_if  req_if ();
  sud_out_if res_if ();

  divide_scoreboard sb = new();

  signed_unsigned_divider dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_request(logic kind, field_t dividend, field_t divisor);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= kind;
    req_if.dividend <= dividend;
    req_if.divisor  <= divisor;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(kind, dividend, divisor);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic field_t pick_operand();
    case ($urandom_range(0, 5))
      0: return field_t'($urandom_range(0, 15));
      1: return field_t'(0) - field_t'($urandom_range(1, 16));
      2: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return field_t'(1);
          2: return '1;
          3: return {1'b1, {(FIELD_W - 1){1'b0}}};
          default: return {1'b0, {(FIELD_W - 1){1'b1}}};
        endcase
      end
      3: return field_t'($urandom) >> $urandom_range(0, FIELD_W - 1);
      default: return field_t'($urandom);
    endcase
  endfunction

  // result side: random stall before each result, then hold ready until one is taken
  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      sb.check_result(res_if.quotient, res_if.remainder);
    end
  end

  initial begin
    field_t corner_a[12];
    field_t corner_b[12];
    corner_a = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'hFFFF_FFF9, 32'h7, 32'hFFFF_FFF9, 32'h7FFF_FFFF, 32'h64, 32'h7};
    corner_b = '{32'h0, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                 32'h2, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7, 32'h0};

    rst_ni          = 1'b0;
    burst           = 1'b0;
    req_if.valid    <= 1'b0;
    req_if.kind     <= KIND_UNSIGNED;
    req_if.dividend <= '0;
    req_if.divisor  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners in both modes: zero divisor, min / -1, mixed signs, max / min
    for (int i = 0; i < 12; i++) begin
      send_request(KIND_UNSIGNED, corner_a[i], corner_b[i]);
      send_request(KIND_SIGNED, corner_a[i], corner_b[i]);
    end
    req_if.valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_REQUESTS / 2) begin
        req_if.valid <= 1'b0;
        wait_drained();
      end
      send_request(logic'($urandom_range(0, 1)), pick_operand(), pick_operand());
    end
    req_if.valid <= 1'b0;
    burst = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
